/* hdl/fdss_pkg.sv */
// ----------------------------------------------------------------------------
// fdss_pkg
// Shared types, constants and the glyph table of the display scanner.
// ----------------------------------------------------------------------------
package fdss_pkg;

    // Beat kinds carried on the input tuser bit
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_SHOW = 1'b1;

    localparam int NUM_WIDTH   = 16;
    localparam int VAL_WIDTH   = 14;   // holds 0..9999
    localparam int DIGIT_WIDTH = 4;
    localparam int SEG_WIDTH   = 8;
    localparam int NUM_DIGITS  = 4;
    localparam int IDX_WIDTH   = 2;

    localparam logic [VAL_WIDTH-1:0] CLAMP_MAX    = 14'd9999;
    localparam logic [SEG_WIDTH-1:0] SEGS_ALL_OFF = 8'hFF;

    // Decimal digits of one shown number, thousands first
    typedef struct packed {
        logic [DIGIT_WIDTH-1:0] thousands;
        logic [DIGIT_WIDTH-1:0] hundreds;
        logic [DIGIT_WIDTH-1:0] tens;
        logic [DIGIT_WIDTH-1:0] units;
    } digits_t;

    // Load strobes for the split pipeline
    typedef struct packed {
        logic load1;
        logic load2;
    } pipe_ctrl_t;

    // Active-low segments, bits F E D C B G DP A from the MSB down
    function automatic logic [SEG_WIDTH-1:0] glyph(input logic [DIGIT_WIDTH-1:0] digit);
        logic [SEG_WIDTH-1:0] pat;
        case (digit)
            4'd0:    pat = 8'b00000110;
            4'd1:    pat = 8'b11100111;
            4'd2:    pat = 8'b10010010;
            4'd3:    pat = 8'b11000010;
            4'd4:    pat = 8'b01100011;
            4'd5:    pat = 8'b01001010;
            4'd6:    pat = 8'b00001010;
            4'd7:    pat = 8'b11100110;
            4'd8:    pat = 8'b00000010;
            4'd9:    pat = 8'b01000010;
            default: pat = SEGS_ALL_OFF;
        endcase
        return pat;
    endfunction

endpackage

/* hdl/fdss_digit_split.sv */
// ----------------------------------------------------------------------------
// fdss_digit_split
// Clamps a signed number to 0..9999 and splits it into decimal digits over
// two register stages; tens and units come out of the last stage's logic.
// ----------------------------------------------------------------------------
module fdss_digit_split (
    input  logic                                  aclk,
    input  fdss_pkg::pipe_ctrl_t                  ctrl,
    input  logic signed [fdss_pkg::NUM_WIDTH-1:0] number_in,
    output fdss_pkg::digits_t                     digits
);

    localparam int DW = fdss_pkg::DIGIT_WIDTH;
    localparam int VW = fdss_pkg::VAL_WIDTH;

    // Stage 1: thousands and remainder below 1000
    logic [DW-1:0] th_reg,  th_next;
    logic [9:0]    r1_reg,  r1_next;
    // Stage 2: thousands, hundreds and remainder below 100
    logic [DW-1:0] th2_reg;
    logic [DW-1:0] hund_reg, hund_next;
    logic [6:0]    r2_reg,   r2_next;

    logic [VW-1:0] value;
    logic [VW-1:0] r1_wide;
    logic [9:0]    r2_wide;
    logic [14:0]   tens_prod;
    logic [DW-1:0] tens;
    logic [6:0]    units_wide;

    // Clamp: negative to zero, above 9999 to 9999
    always_comb begin
        if (number_in[fdss_pkg::NUM_WIDTH-1]) begin
            value = '0;
        end else if (number_in[fdss_pkg::NUM_WIDTH-2:0] > 15'(fdss_pkg::CLAMP_MAX)) begin
            value = fdss_pkg::CLAMP_MAX;
        end else begin
            value = number_in[VW-1:0];
        end
    end

    // Thousands by a bank of independent compares
    always_comb begin
        th_next = '0;
        for (int k = 1; k < 10; k++) begin
            if (value >= VW'(k * 1000)) begin
                th_next = DW'(k);
            end
        end
        r1_wide = value - VW'(th_next * 14'd1000);
        r1_next = r1_wide[9:0];
    end

    // Hundreds, same scheme on the remainder
    always_comb begin
        hund_next = '0;
        for (int k = 1; k < 10; k++) begin
            if (r1_reg >= 10'(k * 100)) begin
                hund_next = DW'(k);
            end
        end
        r2_wide = r1_reg - 10'(hund_next * 10'd100);
        r2_next = r2_wide[6:0];
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load1) begin
            th_reg <= th_next;
            r1_reg <= r1_next;
        end
        if (ctrl.load2) begin
            th2_reg  <= th_reg;
            hund_reg <= hund_next;
            r2_reg   <= r2_next;
        end
    end

    // Tens: r2 * 205 >> 11 is exact for 0..99
    assign tens_prod  = 15'(r2_reg) * 15'd205;
    assign tens       = tens_prod[14:11];
    assign units_wide = r2_reg - 7'(tens * 7'd10);

    assign digits.thousands = th2_reg;
    assign digits.hundreds  = hund_reg;
    assign digits.tens      = tens;
    assign digits.units     = units_wide[DW-1:0];

endmodule

/* hdl/four_digit_seven_segment_scanner.sv */
// ----------------------------------------------------------------------------
// four_digit_seven_segment_scanner
// Four-digit multiplexed seven-segment display scanner with stream ports.
// ----------------------------------------------------------------------------
// Each input beat is either a show (tuser high), which clamps the signed
// tdata number to 0..9999 and stores its four decimal digits with no result,
// or a refresh tick (tuser low), which returns one result beat with the
// active-low segment pattern of the current digit and an active-low digit
// enable, then moves the scan to the next digit (thousands first, wrapping
// after units). One beat is taken every cycle while m_tready does not hold back
// a result; a tick's beat lands in the input register, then passes the two
// stages of the decimal split and the output register. Beats keep their order,
// so a tick always shows the digits of every show accepted before it.
// ----------------------------------------------------------------------------
module four_digit_seven_segment_scanner (
    input  logic        aclk,
    input  logic        aresetn,
    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] number
    input  logic        s_tuser,   // [0] action
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [7:0] segment_pattern, [11:8] digit_enable
);

    localparam int DW = fdss_pkg::DIGIT_WIDTH;
    localparam int IW = fdss_pkg::IDX_WIDTH;
    localparam int ND = fdss_pkg::NUM_DIGITS;

    // Pipeline control state
    logic s0_valid_reg, s0_valid_next;
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic s0_action_reg, s1_action_reg, s2_action_reg;
    logic signed [fdss_pkg::NUM_WIDTH-1:0] s0_number_reg;

    logic [IW-1:0] scan_reg, scan_next;
    logic [DW-1:0] store_reg [ND];

    logic        m_valid_reg, m_valid_next;
    logic [7:0]  seg_reg;
    logic [3:0]  en_reg;

    logic accept, go_out, move2, ready2, ready1, tick_out, show_out;
    fdss_pkg::pipe_ctrl_t ctrl;
    fdss_pkg::digits_t    digits;

    // Handshake and stage advance: a stage loads when it is empty or drains
    assign go_out   = !m_valid_reg || m_tready;
    assign tick_out = s2_valid_reg && (s2_action_reg == fdss_pkg::ACT_TICK) && go_out;
    assign show_out = s2_valid_reg && (s2_action_reg == fdss_pkg::ACT_SHOW);
    assign move2    = tick_out || show_out;
    assign ready2   = !s2_valid_reg || move2;
    assign ready1   = !s1_valid_reg || ready2;
    assign ctrl.load2 = s1_valid_reg && ready2;
    assign ctrl.load1 = s0_valid_reg && ready1;
    assign s_tready = !s0_valid_reg || ready1;
    assign accept   = s_tvalid && s_tready;

    fdss_digit_split u_split (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .number_in (s0_number_reg),
        .digits    (digits)
    );

    // Valid bits follow the loads
    always_comb begin
        s0_valid_next = accept     ? 1'b1 : (ctrl.load1 ? 1'b0 : s0_valid_reg);
        s1_valid_next = ctrl.load1 ? 1'b1 : (ctrl.load2 ? 1'b0 : s1_valid_reg);
        s2_valid_next = ctrl.load2 ? 1'b1 : (move2      ? 1'b0 : s2_valid_reg);
        m_valid_next  = go_out ? tick_out : m_valid_reg;
        scan_next     = tick_out ? scan_reg + IW'(1) : scan_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            scan_reg     <= '0;
        end else begin
            s0_valid_reg <= s0_valid_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            m_valid_reg  <= m_valid_next;
            scan_reg     <= scan_next;
        end
    end

    // Digit store: cleared by reset, written by a show leaving the pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ND; i++) begin
                store_reg[i] <= '0;
            end
        end else if (show_out) begin
            store_reg[0] <= digits.thousands;
            store_reg[1] <= digits.hundreds;
            store_reg[2] <= digits.tens;
            store_reg[3] <= digits.units;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            s0_action_reg <= s_tuser;
            s0_number_reg <= s_tdata;
        end
        if (ctrl.load1) begin
            s1_action_reg <= s0_action_reg;
        end
        if (ctrl.load2) begin
            s2_action_reg <= s1_action_reg;
        end
        // result beat from a tick
        if (tick_out) begin
            seg_reg <= fdss_pkg::glyph(store_reg[scan_reg]);
            en_reg  <= ~(4'(1) << scan_reg);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, en_reg, seg_reg};

endmodule
